[sv/sip_pkg.sv]
// sip_pkg: widths, types and the divider step for the segment intersection pipeline
// used by segment_intersection_point; depends on nothing
package sip_pkg;

	localparam int COORD_BITS = 16;
	localparam int FRAC_BITS  = 8;
	localparam int DIF_W      = COORD_BITS + 1;
	localparam int PRD_W      = 2 * DIF_W;
	localparam int DET_W      = PRD_W + 1;
	localparam int OUT_W      = COORD_BITS + FRAC_BITS;
	localparam int STEPS      = OUT_W;
	localparam int STEP_W     = DET_W + 2;
	localparam int NST        = STEPS + 5;
	localparam int IN_W       = 8 * COORD_BITS;
	localparam int IN_BYTES   = (IN_W + 7) / 8;
	localparam int OD_W       = 2 * OUT_W;
	localparam int OD_BYTES   = (OD_W + 7) / 8;

	typedef struct packed {
		logic [DET_W-1:0] rem;
		logic [1:0]       k;
	} div_step_t;

	// one step of floor(tn * m / den), adding a quotient digit of 0 to 2, with tn < den and rem < den
	function automatic div_step_t div_step(input logic [DET_W-1:0] rem,
		input logic [DET_W-1:0] tn, input logic [DET_W-1:0] den, input logic mbit);
		logic [STEP_W-1:0] t;
		logic [STEP_W-1:0] d1;
		logic [STEP_W-1:0] d2;
		div_step_t r;
		t  = {1'b0, rem, 1'b0} + (mbit ? STEP_W'(tn) : '0);
		d1 = STEP_W'(den);
		d2 = {1'b0, den, 1'b0};
		r.k = 2'd0;
		if (t >= d2) begin
			t   = t - d2;
			r.k = 2'd2;
		end
		if (t >= d1) begin
			t   = t - d1;
			r.k = r.k + 2'd1;
		end
		r.rem = t[DET_W-1:0];
		return r;
	endfunction

endpackage

[sv/segment_intersection_point.sv]
// segment_intersection_point: pipelined 2d segment crossing test and crossing point
// depends on sip_pkg (widths, divider step)
//
// usage: one request on the slave stream carries both segments; one result
// request per input leaves on the master stream with hit in tuser and the
// crossing point in tdata (8 fraction bits, zero on a miss).
// stages: differences, six products, determinant and numerators, sign
// normalisation and range check, then 24 restoring divider steps (one
// quotient bit per stage, x and y side by side), then the output register.
// throughput is one request per cycle, set by the one-bit-per-stage divider
// pipeline, while the receiver keeps m_tready high.
// every stage holds its own valid bit and loads whenever it is empty or its
// successor moves, so bubbles close up and input is still taken while the
// receiver stalls, until the whole pipeline is full.
// reset clears the valid bits only; the pipeline is empty after reset.
// nothing is lost or repeated while m_tready is low.
module segment_intersection_point
	import sip_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	// a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y, b_end_x, b_end_y
	input  logic [8*IN_BYTES-1:0]   s_tdata,
	output logic                    m_tvalid,
	input  logic                    m_tready,
	// cross_x, cross_y
	output logic [8*OD_BYTES-1:0]   m_tdata,
	// hit
	output logic [0:0]              m_tuser
);

	logic [NST-1:0] vld_q;
	logic [NST-1:0] rdy;

	always_comb begin
		rdy[NST-1] = !vld_q[NST-1] || m_tready;
		for (int k = NST - 2; k >= 0; k--) begin
			rdy[k] = !vld_q[k] || rdy[k+1];
		end
	end

	assign s_tready = rdy[0];
	assign m_tvalid = vld_q[NST-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (rdy[0]) vld_q[0] <= s_tvalid;
			for (int k = 1; k < NST; k++) begin
				if (rdy[k]) vld_q[k] <= vld_q[k-1];
			end
		end
	end

	// input fields
	logic signed [COORD_BITS-1:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
	assign ax0 = s_tdata[0*COORD_BITS +: COORD_BITS];
	assign ay0 = s_tdata[1*COORD_BITS +: COORD_BITS];
	assign ax1 = s_tdata[2*COORD_BITS +: COORD_BITS];
	assign ay1 = s_tdata[3*COORD_BITS +: COORD_BITS];
	assign bx0 = s_tdata[4*COORD_BITS +: COORD_BITS];
	assign by0 = s_tdata[5*COORD_BITS +: COORD_BITS];
	assign bx1 = s_tdata[6*COORD_BITS +: COORD_BITS];
	assign by1 = s_tdata[7*COORD_BITS +: COORD_BITS];

	// stage 1: differences
	logic signed [DIF_W-1:0]      rx_s1, ry_s1, qx_s1, qy_s1, dx_s1, dy_s1;
	logic signed [COORD_BITS-1:0] ax_s1, ay_s1;
	// stage 2: products
	logic signed [PRD_W-1:0]      p0_s2, p1_s2, p2_s2, p3_s2, p4_s2, p5_s2;
	logic signed [DIF_W-1:0]      rx_s2, ry_s2;
	logic signed [COORD_BITS-1:0] ax_s2, ay_s2;
	// stage 3: determinant and numerators
	logic signed [DET_W-1:0]      den_s3, tn_s3, sn_s3;
	logic signed [DIF_W-1:0]      rx_s3, ry_s3;
	logic signed [COORD_BITS-1:0] ax_s3, ay_s3;
	// divider stages, index 0 is the normalised stage
	logic [DET_W-1:0]  den_sd  [STEPS+1];
	logic [DET_W-1:0]  tn_sd   [STEPS+1];
	logic [DET_W-1:0]  remx_sd [STEPS+1];
	logic [DET_W-1:0]  remy_sd [STEPS+1];
	logic [OUT_W-1:0]  quox_sd [STEPS+1];
	logic [OUT_W-1:0]  quoy_sd [STEPS+1];
	logic [OUT_W-1:0]  mx_sd   [STEPS+1];
	logic [OUT_W-1:0]  my_sd   [STEPS+1];
	logic [OUT_W-1:0]  basex_sd[STEPS+1];
	logic [OUT_W-1:0]  basey_sd[STEPS+1];
	logic              negx_sd [STEPS+1];
	logic              negy_sd [STEPS+1];
	logic              hit_sd  [STEPS+1];
	// output register
	logic              hit_q;
	logic [OUT_W-1:0]  crx_q, cry_q;

	// normalisation
	logic signed [DET_W-1:0] den_n, tn_n, sn_n;
	logic                    hit_n;
	logic [DIF_W-1:0]        magx, magy;

	always_comb begin
		den_n = den_s3[DET_W-1] ? -den_s3 : den_s3;
		tn_n  = den_s3[DET_W-1] ? -tn_s3  : tn_s3;
		sn_n  = den_s3[DET_W-1] ? -sn_s3  : sn_s3;
		hit_n = (den_s3 != '0) && !tn_n[DET_W-1] && (tn_n < den_n)
			&& !sn_n[DET_W-1] && (sn_n < den_n);
		magx  = rx_s3[DIF_W-1] ? DIF_W'(-rx_s3) : DIF_W'(rx_s3);
		magy  = ry_s3[DIF_W-1] ? DIF_W'(-ry_s3) : DIF_W'(ry_s3);
	end

	div_step_t stx [STEPS];
	div_step_t sty [STEPS];

	always_comb begin
		for (int j = 0; j < STEPS; j++) begin
			stx[j] = div_step(remx_sd[j], tn_sd[j], den_sd[j], mx_sd[j][STEPS-1-j]);
			sty[j] = div_step(remy_sd[j], tn_sd[j], den_sd[j], my_sd[j][STEPS-1-j]);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[0]) begin
			rx_s1 <= DIF_W'(ax1) - DIF_W'(ax0);
			ry_s1 <= DIF_W'(ay1) - DIF_W'(ay0);
			qx_s1 <= DIF_W'(bx1) - DIF_W'(bx0);
			qy_s1 <= DIF_W'(by1) - DIF_W'(by0);
			dx_s1 <= DIF_W'(bx0) - DIF_W'(ax0);
			dy_s1 <= DIF_W'(by0) - DIF_W'(ay0);
			ax_s1 <= ax0;
			ay_s1 <= ay0;
		end
		if (rdy[1]) begin
			p0_s2 <= PRD_W'(rx_s1) * PRD_W'(qy_s1);
			p1_s2 <= PRD_W'(ry_s1) * PRD_W'(qx_s1);
			p2_s2 <= PRD_W'(dx_s1) * PRD_W'(qy_s1);
			p3_s2 <= PRD_W'(dy_s1) * PRD_W'(qx_s1);
			p4_s2 <= PRD_W'(dx_s1) * PRD_W'(ry_s1);
			p5_s2 <= PRD_W'(dy_s1) * PRD_W'(rx_s1);
			rx_s2 <= rx_s1;
			ry_s2 <= ry_s1;
			ax_s2 <= ax_s1;
			ay_s2 <= ay_s1;
		end
		if (rdy[2]) begin
			den_s3 <= DET_W'(p0_s2) - DET_W'(p1_s2);
			tn_s3  <= DET_W'(p2_s2) - DET_W'(p3_s2);
			sn_s3  <= DET_W'(p4_s2) - DET_W'(p5_s2);
			rx_s3  <= rx_s2;
			ry_s3  <= ry_s2;
			ax_s3  <= ax_s2;
			ay_s3  <= ay_s2;
		end
		if (rdy[3]) begin
			den_sd[0]   <= den_n;
			tn_sd[0]    <= hit_n ? DET_W'(tn_n) : '0;
			remx_sd[0]  <= '0;
			remy_sd[0]  <= '0;
			quox_sd[0]  <= '0;
			quoy_sd[0]  <= '0;
			mx_sd[0]    <= {magx[COORD_BITS-1:0], {FRAC_BITS{1'b0}}};
			my_sd[0]    <= {magy[COORD_BITS-1:0], {FRAC_BITS{1'b0}}};
			basex_sd[0] <= {ax_s3, {FRAC_BITS{1'b0}}};
			basey_sd[0] <= {ay_s3, {FRAC_BITS{1'b0}}};
			negx_sd[0]  <= rx_s3[DIF_W-1];
			negy_sd[0]  <= ry_s3[DIF_W-1];
			hit_sd[0]   <= hit_n;
		end
		for (int j = 0; j < STEPS; j++) begin
			if (rdy[4+j]) begin
				den_sd[j+1]   <= den_sd[j];
				tn_sd[j+1]    <= tn_sd[j];
				remx_sd[j+1]  <= stx[j].rem;
				remy_sd[j+1]  <= sty[j].rem;
				quox_sd[j+1]  <= {quox_sd[j][OUT_W-2:0], 1'b0} + OUT_W'(stx[j].k);
				quoy_sd[j+1]  <= {quoy_sd[j][OUT_W-2:0], 1'b0} + OUT_W'(sty[j].k);
				mx_sd[j+1]    <= mx_sd[j];
				my_sd[j+1]    <= my_sd[j];
				basex_sd[j+1] <= basex_sd[j];
				basey_sd[j+1] <= basey_sd[j];
				negx_sd[j+1]  <= negx_sd[j];
				negy_sd[j+1]  <= negy_sd[j];
				hit_sd[j+1]   <= hit_sd[j];
			end
		end
		if (rdy[NST-1]) begin
			hit_q <= hit_sd[STEPS];
			if (!hit_sd[STEPS]) begin
				crx_q <= '0;
				cry_q <= '0;
			end else begin
				crx_q <= negx_sd[STEPS] ? basex_sd[STEPS] - quox_sd[STEPS]
					: basex_sd[STEPS] + quox_sd[STEPS];
				cry_q <= negy_sd[STEPS] ? basey_sd[STEPS] - quoy_sd[STEPS]
					: basey_sd[STEPS] + quoy_sd[STEPS];
			end
		end
	end

	assign m_tdata = (8*OD_BYTES)'({cry_q, crx_q});
	assign m_tuser = hit_q;

endmodule

[tb/testbench.sv]
// testbench for segment_intersection_point: directed table then random segment pairs,
// results checked in order against the table or a local crossing predictor; depends on sip_pkg
module testbench
	import sip_pkg::*;
;

	localparam int N_RANDOM = 800;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [8*IN_BYTES-1:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [8*OD_BYTES-1:0] m_tdata;
	logic [0:0] m_tuser;

	typedef struct packed {
		logic hit;
		logic [OUT_W-1:0] cx;
		logic [OUT_W-1:0] cy;
	} crossing_t;

	typedef struct {
		logic [15:0] c [8];
		logic known;
		crossing_t res;
	} seg_row_t;

	crossing_t pending_crossings [$];
	int mismatches;
	int hold_cycles;
	bit feeding_done;

	segment_intersection_point dut (.*);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		#100000000;
		$display("testbench NOT OK");
		$finish;
	end

	function automatic logic [OUT_W-1:0] coord_at(longint a0, longint diff, longint tn,
		longint den);
		longint q;
		q = (tn * diff * (longint'(1) << FRAC_BITS)) / den;
		return OUT_W'(a0 * (longint'(1) << FRAC_BITS) + q);
	endfunction

	function automatic crossing_t predict_crossing(logic [8*IN_BYTES-1:0] d);
		longint v [8];
		longint rx, ry, qx, qy, dx, dy, den, tn, sn;
		crossing_t r;
		for (int i = 0; i < 8; i++) v[i] = longint'($signed(d[16*i +: 16]));
		rx = v[2] - v[0]; ry = v[3] - v[1];
		qx = v[6] - v[4]; qy = v[7] - v[5];
		dx = v[4] - v[0]; dy = v[5] - v[1];
		den = rx * qy - ry * qx;
		tn = dx * qy - dy * qx;
		sn = dx * ry - dy * rx;
		r = '0;
		if (den < 0) begin
			den = -den; tn = -tn; sn = -sn;
		end
		if (den != 0 && tn >= 0 && tn < den && sn >= 0 && sn < den) begin
			r.hit = 1;
			r.cx = coord_at(v[0], rx, tn, den);
			r.cy = coord_at(v[1], ry, tn, den);
		end
		return r;
	endfunction

	task automatic send_request(logic [8*IN_BYTES-1:0] d, logic known, crossing_t res);
		crossing_t p;
		p = predict_crossing(d);
		if (known && p != res) $display("table row disagrees with predictor: %h", d);
		s_tvalid <= 1;
		s_tdata <= d;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pending_crossings.push_back(known ? res : p);
		if ($urandom_range(0, 3) == 0) begin
			s_tvalid <= 0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	function automatic logic [8*IN_BYTES-1:0] pack_row(seg_row_t r);
		logic [8*IN_BYTES-1:0] d;
		for (int i = 0; i < 8; i++) d[16*i +: 16] = r.c[i];
		return d;
	endfunction

	function automatic logic [15:0] rnd_coord(int mode);
		case (mode)
			0: return 16'($urandom);
			1: return 16'($urandom_range(0, 64) - 32);
			default: return 16'($urandom_range(0, 2000) - 1000);
		endcase
	endfunction

	initial begin
		seg_row_t rows [$];
		seg_row_t r;
		logic [8*IN_BYTES-1:0] d;
		int mode;
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = '0;
		feeding_done = 0;
		// crossing at origin, t = 1/2
		r.c = '{-16'sd2, 16'sd0, 16'sd2, 16'sd0, 16'sd0, -16'sd2, 16'sd0, 16'sd2};
		r.known = 1; r.res = '{1'b1, 24'd0, 24'd0}; rows.push_back(r);
		// parallel
		r.c = '{16'd0, 16'd0, 16'd4, 16'd0, 16'd0, 16'd1, 16'd4, 16'd1};
		r.res = '0; rows.push_back(r);
		// collinear
		r.c = '{16'd0, 16'd0, 16'd4, 16'd0, 16'd1, 16'd0, 16'd6, 16'd0};
		rows.push_back(r);
		// zero length segment
		r.c = '{16'd1, 16'd1, 16'd1, 16'd1, 16'd0, 16'd0, 16'd4, 16'd4};
		rows.push_back(r);
		// t = 0 touching start of a: hit
		r.c = '{16'd0, 16'd0, 16'd4, 16'd0, 16'd0, -16'sd2, 16'd0, 16'd2};
		r.res = '{1'b1, 24'd0, 24'd0}; rows.push_back(r);
		// t = 1 at end of a: miss
		r.c = '{16'd0, 16'd0, 16'd4, 16'd0, 16'd4, -16'sd2, 16'd4, 16'd2};
		r.res = '0; rows.push_back(r);
		// extremes of the coordinate range
		r.c = '{16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000};
		r.known = 0; rows.push_back(r);
		r.c = '{16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff};
		rows.push_back(r);
		r.c = '{16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff};
		r.known = 1; r.res = '0; rows.push_back(r);
		// fractional point, negative direction
		r.c = '{16'd3, 16'd0, -16'sd0, 16'd3, 16'd0, 16'd0, 16'd5, 16'd2};
		r.known = 0; rows.push_back(r);
		r.c = '{16'd0, 16'd0, 16'd7, 16'd3, 16'd1, 16'd5, 16'd6, -16'sd4};
		rows.push_back(r);
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		foreach (rows[i]) send_request(pack_row(rows[i]), rows[i].known, rows[i].res);
		for (int n = 0; n < N_RANDOM; n++) begin
			mode = $urandom_range(0, 2);
			for (int i = 0; i < 8; i++) d[16*i +: 16] = rnd_coord(mode);
			send_request(d, 0, '0);
		end
		s_tvalid <= 0;
		feeding_done = 1;
	end

	initial begin
		m_tready = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				m_tready <= 0;
			end else begin
				m_tready <= ($urandom_range(0, 9) > 2) || ($urandom_range(0, 1) == 0);
			end
		end
	end

	// long receiver hold, counted here while the sender keeps offering
	initial begin
		hold_cycles = 0;
		@(posedge arst_n);
		repeat (100) @(posedge clk);
		hold_cycles = 200;
		while (hold_cycles > 0) begin
			@(posedge clk);
			hold_cycles--;
		end
	end

	always @(posedge clk) begin
		crossing_t want, got;
		if (arst_n && m_tvalid && m_tready) begin
			got = '{m_tuser[0], m_tdata[OUT_W-1:0], m_tdata[2*OUT_W-1:OUT_W]};
			if (pending_crossings.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result request %h", got);
			end else begin
				want = pending_crossings.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: hit %b/%b x %h/%h y %h/%h", want.hit, got.hit,
							want.cx, got.cx, want.cy, got.cy);
				end
			end
		end
	end

	initial begin
		mismatches = 0;
		wait (feeding_done);
		while (pending_crossings.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatches == 0 && pending_crossings.size() == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end
endmodule
